FILE: hw/rtl/fsp_pkg.sv
package fsp_pkg;

   localparam int CharWidth = 8;
   localparam int ArgWidth  = 32;
   localparam int DecDigits = 10;
   localparam int HexDigits = 8;
   localparam int BcdWidth  = 4 * DecDigits;

   localparam logic [CharWidth-1:0] CharNul     = 8'h00;
   localparam logic [CharWidth-1:0] CharZero    = 8'h30;
   localparam logic [CharWidth-1:0] CharUpperA  = 8'h41;
   localparam logic [CharWidth-1:0] CharX       = 8'h78;
   localparam logic [CharWidth-1:0] CharMinus   = 8'h2D;
   localparam logic [CharWidth-1:0] CharPercent = 8'h25;
   localparam logic [CharWidth-1:0] CharLowerC  = 8'h63;
   localparam logic [CharWidth-1:0] CharLowerP  = 8'h70;
   localparam logic [CharWidth-1:0] CharLowerU  = 8'h75;
   localparam logic [CharWidth-1:0] CharLowerI  = 8'h69;

   typedef struct packed {
      logic start;
      logic shift;
   } fsp_bcd_ctrl_type;

   typedef struct packed {
      logic       busy;
      logic [3:0] digit;
   } fsp_bcd_stat_type;

   function automatic logic [CharWidth-1:0] hex_ascii(input logic [3:0] nib);
      logic [CharWidth-1:0] ch;
      if (nib < 4'd10) begin
         ch = CharZero + {4'b0000, nib};
      end else begin
         ch = CharUpperA + {4'b0000, nib - 4'd10};
      end
      return ch;
   endfunction

endpackage

FILE: hw/rtl/fsp_bcd.sv
module fsp_bcd (
   input  logic                          clock,
   input  logic                          reset,
   input  fsp_pkg::fsp_bcd_ctrl_type     ctrl,
   input  logic [fsp_pkg::ArgWidth-1:0]  value,
   output fsp_pkg::fsp_bcd_stat_type     stat
);

   localparam int CntWidth = $clog2(fsp_pkg::ArgWidth);

   logic [fsp_pkg::ArgWidth-1:0] bin_ff, bin_in;
   logic [fsp_pkg::BcdWidth-1:0] bcd_ff, bcd_in;
   logic [CntWidth-1:0]          cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic [fsp_pkg::BcdWidth-1:0] adj;

   // add three to every digit of five or more before each shift
   always_comb begin
      for (int d = 0; d < fsp_pkg::DecDigits; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (ctrl.start) begin
         bin_in  = value;
         bcd_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in = {adj[fsp_pkg::BcdWidth-2:0], bin_ff[fsp_pkg::ArgWidth-1]};
         bin_in = {bin_ff[fsp_pkg::ArgWidth-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntWidth'(fsp_pkg::ArgWidth - 1)) begin
            busy_in = 1'b0;
         end
      end else if (ctrl.shift) begin
         bcd_in = {bcd_ff[fsp_pkg::BcdWidth-5:0], 4'b0000};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign stat.busy  = busy_ff;
   assign stat.digit = bcd_ff[fsp_pkg::BcdWidth-1 -: 4];

endmodule

FILE: hw/rtl/format_string_printer.sv
// Channel | Dir | Beat contents
// req_    | in  | tdata: fmt_char [7:0], arg_value [39:8]; tuser: string_start
// rsp_    | out | tdata: out_char [7:0]; tlast: last_of_run
//
// One beat in at a time: the next req beat is taken once the previous one has loaded
// its last character. %u/%i run the 32-step bit-serial binary to BCD, then ten steps
// that each drop a leading zero or emit a digit; a beat that emits nothing returns
// to idle straight from decode.
// Synchronous active-high reset clears the pending percent and the sequencer.
// rsp_ has a single output register; a stall there holds the sequencer.
module format_string_printer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // fmt_char [7:0], arg_value [39:8]
   input  logic        req_tuser,   // string_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_char [7:0]
   output logic        rsp_tlast
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_PAIR   = 4'd2;
   localparam logic [3:0] S_LAST   = 4'd3;
   localparam logic [3:0] S_HEX0   = 4'd4;
   localparam logic [3:0] S_HEXX   = 4'd5;
   localparam logic [3:0] S_HEXD   = 4'd6;
   localparam logic [3:0] S_SIGN   = 4'd7;
   localparam logic [3:0] S_CONV   = 4'd8;
   localparam logic [3:0] S_DEC    = 4'd9;

   localparam int HexCntWidth = $clog2(fsp_pkg::HexDigits);
   localparam int DecCntWidth = $clog2(fsp_pkg::DecDigits + 1);

   logic [3:0]                    state_ff, state_in;
   logic                          pending_ff, pending_in;
   logic                          start_ff, start_in;
   logic [fsp_pkg::CharWidth-1:0] char_ff, char_in;
   logic [fsp_pkg::ArgWidth-1:0]  arg_ff, arg_in;
   logic [HexCntWidth-1:0]        hex_cnt_ff, hex_cnt_in;
   logic [DecCntWidth-1:0]        dec_cnt_ff, dec_cnt_in;
   logic                          lead_ff, lead_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [fsp_pkg::CharWidth-1:0] rsp_char_ff, rsp_char_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          can_load;
   logic                          load;
   logic [fsp_pkg::CharWidth-1:0] load_char;
   logic                          load_last;
   logic                          pend_eff;
   logic [fsp_pkg::ArgWidth-1:0]  conv_value;
   fsp_pkg::fsp_bcd_ctrl_type     bcd_ctrl;
   fsp_pkg::fsp_bcd_stat_type     bcd_stat;

   assign req_tready = (state_ff == S_IDLE);
   assign can_load   = !rsp_valid_ff || rsp_tready;
   assign pend_eff   = pending_ff && !start_ff;

   fsp_bcd u_bcd (
      .clock (clock),
      .reset (reset),
      .ctrl  (bcd_ctrl),
      .value (conv_value),
      .stat  (bcd_stat)
   );

   always_comb begin
      state_in       = state_ff;
      pending_in     = pending_ff;
      start_in       = start_ff;
      char_in        = char_ff;
      arg_in         = arg_ff;
      hex_cnt_in     = hex_cnt_ff;
      dec_cnt_in     = dec_cnt_ff;
      lead_in        = lead_ff;
      load           = 1'b0;
      load_char      = char_ff;
      load_last      = 1'b0;
      bcd_ctrl.start = 1'b0;
      bcd_ctrl.shift = 1'b0;
      conv_value     = arg_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               char_in  = req_tdata[7:0];
               arg_in   = req_tdata[39:8];
               start_in = req_tuser;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in   = S_IDLE;
            pending_in = 1'b0;
            hex_cnt_in = '0;
            dec_cnt_in = DecCntWidth'(fsp_pkg::DecDigits);
            lead_in    = 1'b1;
            if (char_ff == fsp_pkg::CharNul) begin
               state_in = S_IDLE;
            end else if (!pend_eff) begin
               if (char_ff == fsp_pkg::CharPercent) begin
                  pending_in = 1'b1;
               end else begin
                  state_in = S_LAST;
               end
            end else begin
               case (char_ff)
                  fsp_pkg::CharLowerC: begin
                     char_in  = arg_ff[7:0];
                     state_in = S_LAST;
                  end
                  fsp_pkg::CharX, fsp_pkg::CharLowerP: begin
                     state_in = S_HEX0;
                  end
                  fsp_pkg::CharLowerU: begin
                     bcd_ctrl.start = 1'b1;
                     state_in       = S_CONV;
                  end
                  fsp_pkg::CharLowerI: begin
                     bcd_ctrl.start = 1'b1;
                     if (arg_ff[fsp_pkg::ArgWidth-1]) begin
                        conv_value = '0 - arg_ff;
                        state_in   = S_SIGN;
                     end else begin
                        state_in = S_CONV;
                     end
                  end
                  fsp_pkg::CharPercent: begin
                     state_in = S_LAST;
                  end
                  default: begin
                     state_in = S_PAIR;
                  end
               endcase
            end
         end
         S_PAIR: begin
            if (can_load) begin
               load      = 1'b1;
               load_char = fsp_pkg::CharPercent;
               state_in  = S_LAST;
            end
         end
         S_LAST: begin
            if (can_load) begin
               load      = 1'b1;
               load_char = char_ff;
               load_last = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_HEX0: begin
            if (can_load) begin
               load      = 1'b1;
               load_char = fsp_pkg::CharZero;
               state_in  = S_HEXX;
            end
         end
         S_HEXX: begin
            if (can_load) begin
               load      = 1'b1;
               load_char = fsp_pkg::CharX;
               state_in  = S_HEXD;
            end
         end
         S_HEXD: begin
            load_char = fsp_pkg::hex_ascii(arg_ff[fsp_pkg::ArgWidth-1 -: 4]);
            load_last = (hex_cnt_ff == HexCntWidth'(fsp_pkg::HexDigits - 1));
            if (can_load) begin
               load       = 1'b1;
               arg_in     = {arg_ff[fsp_pkg::ArgWidth-5:0], 4'b0000};
               hex_cnt_in = hex_cnt_ff + 1'b1;
               if (load_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SIGN: begin
            if (can_load) begin
               load      = 1'b1;
               load_char = fsp_pkg::CharMinus;
               state_in  = S_CONV;
            end
         end
         S_CONV: begin
            if (!bcd_stat.busy) begin
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            load_char = fsp_pkg::CharZero + {4'b0000, bcd_stat.digit};
            load_last = (dec_cnt_ff == DecCntWidth'(1));
            if (lead_ff && (bcd_stat.digit == 4'd0) && !load_last) begin
               // drop a leading zero
               bcd_ctrl.shift = 1'b1;
               dec_cnt_in     = dec_cnt_ff - 1'b1;
            end else if (can_load) begin
               load           = 1'b1;
               lead_in        = 1'b0;
               bcd_ctrl.shift = 1'b1;
               dec_cnt_in     = dec_cnt_ff - 1'b1;
               if (load_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = load_char;
         rsp_last_in  = load_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      start_ff    <= start_in;
      char_ff     <= char_in;
      arg_ff      <= arg_in;
      hex_cnt_ff  <= hex_cnt_in;
      dec_cnt_ff  <= dec_cnt_in;
      lead_ff     <= lead_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_DECODE))
      else $error("accepted beat did not reach decode");

   a_no_idle_load: assert property (@(posedge clock) disable iff (reset)
      !(load && (state_ff == S_IDLE || state_ff == S_DECODE || state_ff == S_CONV)))
      else $error("character loaded outside an emitting state");

   a_dec_after_conv: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DEC) |-> !bcd_stat.busy)
      else $error("decimal digits read while conversion busy");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (load && load_last) |=> (state_ff == S_IDLE))
      else $error("sequencer continued after final character");

endmodule
